// File: sv/mif_pkg.sv
package mif_pkg;
   localparam int WORD_BITS_DEFAULT = 31;
   localparam int MODULUS_RESET     = 2;
endpackage

// File: sv/mif_gcd.sv
// Binary-free Euclid by serial restoring remainder: a % b one bit per cycle.
module mif_gcd #(
   parameter int WORD_BITS = mif_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] a_value,
   input  logic [WORD_BITS-1:0] b_value,
   output logic                 done,
   output logic                 is_one,
   output logic [WORD_BITS-1:0] rem_value
);
   import mif_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_NEXT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, q_ff, q_in;
   logic [WORD_BITS:0]   r_ff, r_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 first_ff, first_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic                 done_ff, done_in, one_ff, one_in;
   logic [WORD_BITS:0]   shifted, diff;

   always_comb begin
      shifted  = {r_ff[WORD_BITS-1:0], q_ff[WORD_BITS-1]};
      diff     = shifted - {1'b0, b_ff};
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      one_in   = one_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in     = a_value;
               b_in     = b_value;
               first_in = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (b_ff == '0) begin
               one_in   = (a_ff == WORD_BITS'(1));
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               q_in     = a_ff;
               r_in     = '0;
               cnt_in   = CW'(WORD_BITS);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            q_in = {q_ff[WORD_BITS-2:0], 1'b0};
            if (!diff[WORD_BITS]) r_in = diff;
            else r_in = shifted;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (first_ff) rem_in = r_in[WORD_BITS-1:0];
               first_in = 1'b0;
               a_in     = b_ff;
               b_in     = r_in[WORD_BITS-1:0];
               state_in = S_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
      rem_ff   <= rem_in;
      one_ff   <= one_in;
   end

   assign done      = done_ff;
   assign is_one    = one_in;
   assign rem_value = rem_ff;

   a_rem_lt_b: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CW'(1)) |=> (b_ff < a_ff))
      else $error("remainder not below divisor");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == S_IDLE))
      else $error("done outside idle");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff != '0))
      else $error("divide count ran out");
endmodule

// File: sv/mif_mulmod.sv
// Serial shift-and-add modular multiply, one multiplier bit per cycle, MSB first.
module mif_mulmod #(
   parameter int WORD_BITS = mif_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] x_value,
   input  logic [WORD_BITS-1:0] y_value,
   input  logic [WORD_BITS-1:0] m_value,
   output logic                 done,
   output logic [WORD_BITS-1:0] product
);
   import mif_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] r_ff, r_in, y_ff, y_in, x_ff, x_in, m_ff, m_in;
   logic [WORD_BITS:0]   dbl, dbl_sub, add, add_sub;
   logic [WORD_BITS-1:0] r_dbl;

   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_sub = dbl - {1'b0, m_ff};
      r_dbl   = dbl_sub[WORD_BITS] ? dbl[WORD_BITS-1:0] : dbl_sub[WORD_BITS-1:0];
      add     = {1'b0, r_dbl} + {1'b0, x_ff};
      add_sub = add - {1'b0, m_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      y_in    = y_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = CW'(WORD_BITS);
            r_in    = '0;
            x_in    = x_value;
            y_in    = y_value;
            m_in    = m_value;
         end
      end else begin
         if (y_ff[WORD_BITS-1])
            r_in = add_sub[WORD_BITS] ? add[WORD_BITS-1:0] : add_sub[WORD_BITS-1:0];
         else
            r_in = r_dbl;
         y_in   = {y_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      y_ff   <= y_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while busy");
   a_res_lt_m: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (r_ff < m_ff))
      else $error("product not reduced");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("count ran out while busy");
endmodule

// File: sv/modular_inverse_fermat.sv
// channel | ports                          | direction
// request | req_valid req_stall req_value   | in word
// result  | rsp_valid rsp_stall rsp_inverse rsp_has_inverse | out word
// csr     | csr_write csr_data              | modulus write
//
// Euclid: serial restoring remainder, one division step after another.
// Exponent: per exponent bit a modular square of the base, preceded by a multiply
// into the accumulator when the bit is set.
// Reset clears control and loads modulus 2. req_stall is high from accept until the
// result has been moved to the output register; a new word is accepted after that.
module modular_inverse_fermat #(
   parameter int WORD_BITS = mif_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_inverse,
   output logic                 rsp_has_inverse,
   input  logic                 csr_write,
   input  logic [WORD_BITS-1:0] csr_data
);
   import mif_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GCD   = 3'd1;
   localparam logic [2:0] S_BIT   = 3'd2;
   localparam logic [2:0] S_MACC  = 3'd3;
   localparam logic [2:0] S_MSQ   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [WORD_BITS-1:0] mod_ff, v_ff, v_in, acc_ff, acc_in, base_ff, base_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in, m_ff, m_in;
   logic                 ov_ff, ov_in;
   logic [WORD_BITS-1:0] inv_ff, inv_in;
   logic                 has_ff, has_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic                 res_has_ff, res_has_in;

   logic gcd_start, gcd_done, gcd_one;
   logic [WORD_BITS-1:0] gcd_rem;
   logic mul_start, mul_done;
   logic [WORD_BITS-1:0] mul_x, mul_y, mul_p;

   assign req_stall = (state_ff != S_IDLE);

   mif_gcd #(.WORD_BITS(WORD_BITS)) u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start),
      .a_value(v_ff), .b_value(m_ff),
      .done(gcd_done), .is_one(gcd_one), .rem_value(gcd_rem));

   mif_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .x_value(mul_x), .y_value(mul_y), .m_value(m_ff),
      .done(mul_done), .product(mul_p));

   always_comb begin
      state_in   = state_ff;
      v_in       = v_ff;
      m_in       = m_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      exp_in     = exp_ff;
      ov_in      = ov_ff;
      inv_in     = inv_ff;
      has_in     = has_ff;
      res_in     = res_ff;
      res_has_in = res_has_ff;
      gcd_start  = 1'b0;
      mul_start  = 1'b0;
      mul_x      = acc_ff;
      mul_y      = base_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               v_in = req_value;
               m_in = mod_ff;
               if (mod_ff < WORD_BITS'(2)) begin
                  res_in     = '0;
                  res_has_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            gcd_start = !gcd_done;
            if (gcd_done) begin
               if (!gcd_one) begin
                  res_in     = '0;
                  res_has_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  acc_in   = WORD_BITS'(1);
                  base_in  = gcd_rem; // v % m from first division
                  exp_in   = m_ff - WORD_BITS'(2);
                  state_in = S_BIT;
               end
            end
         end
         S_BIT: begin
            if (exp_ff == '0) begin
               res_in     = acc_ff;
               res_has_in = 1'b1;
               state_in   = S_DONE;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               state_in  = S_MACC;
            end else begin
               mul_x     = base_ff;
               mul_start = 1'b1;
               state_in  = S_MSQ;
            end
         end
         S_MACC: begin
            if (mul_done) begin
               acc_in    = mul_p;
               mul_x     = base_ff;
               mul_start = 1'b1;
               state_in  = S_MSQ;
            end
         end
         S_MSQ: begin
            if (mul_done) begin
               base_in  = mul_p;
               exp_in   = exp_ff >> 1;
               state_in = S_BIT;
            end
         end
         S_DONE: begin
            // output register free or its word leaves at this edge
            if (!ov_ff || !rsp_stall) begin
               inv_in   = res_ff;
               has_in   = res_has_ff;
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (ov_ff && !rsp_stall && !(state_ff == S_DONE)) ov_in = 1'b0;
   end

   // gcd_start stays high in S_GCD; the gcd unit samples it only while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mod_ff   <= WORD_BITS'(MODULUS_RESET);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         if (csr_write) mod_ff <= csr_data;
      end
      v_ff       <= v_in;
      m_ff       <= m_in;
      acc_ff     <= acc_in;
      base_ff    <= base_in;
      exp_ff     <= exp_in;
      res_ff     <= res_in;
      res_has_ff <= res_has_in;
      inv_ff     <= inv_in;
      has_ff     <= has_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_inverse     = inv_ff;
   assign rsp_has_inverse = has_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("accept while busy");
   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_inverse) |-> (rsp_inverse < m_ff))
      else $error("inverse not reduced");
   a_noinv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_inverse) |-> (rsp_inverse == '0))
      else $error("no-inverse result nonzero");
endmodule

// File: verif/tb_modular_inverse_fermat.sv
class inverse_scoreboard;
   typedef struct {
      logic [30:0] inverse;
      logic        has_inverse;
   } inverse_type;

   inverse_type      pending[$];
   longint unsigned  modulus;
   int               errors;

   function new();
      modulus = mif_pkg::MODULUS_RESET;
      errors  = 0;
   endfunction

   function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // operands stay below 2^31, so products fit in 64 bits
   function inverse_type invert(logic [30:0] value);
      inverse_type     r;
      longint unsigned acc, base, expo;
      r.inverse     = '0;
      r.has_inverse = 1'b0;
      if (modulus < 2 || gcd_of(value, modulus) != 1) return r;
      acc  = 1;
      base = value % modulus;
      expo = modulus - 2;
      while (expo != 0) begin
         if (expo[0]) acc = (acc * base) % modulus;
         base = (base * base) % modulus;
         expo = expo >> 1;
      end
      r.inverse     = acc[30:0];
      r.has_inverse = 1'b1;
      return r;
   endfunction

   function void note_word(logic [30:0] value);
      pending.push_back(invert(value));
   endfunction

   function void check_word(logic [30:0] inverse, logic has_inverse);
      inverse_type exp_r;
      if (pending.size() == 0) begin
         $error("result with no word pending: inverse %0d", inverse);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (inverse !== exp_r.inverse) begin
         $error("inverse: expected %0d actual %0d", exp_r.inverse, inverse);
         errors++;
      end
      if (has_inverse !== exp_r.has_inverse) begin
         $error("has_inverse: expected %0d actual %0d", exp_r.has_inverse, has_inverse);
         errors++;
      end
   endfunction
endclass

module tb_modular_inverse_fermat;
   localparam logic [30:0] MAX_WORD = 31'h7fffffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [30:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [30:0] rsp_inverse;
   logic        rsp_has_inverse;
   logic        csr_write = 1'b0;
   logic [30:0] csr_data = '0;

   inverse_scoreboard sb = new();
   bit   quiet_sender;
   int   results_seen = 0;

   modular_inverse_fermat uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inverse(rsp_inverse), .rsp_has_inverse(rsp_has_inverse),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_inverse, rsp_has_inverse);
         results_seen++;
      end
   end

   task send_word(logic [30:0] value);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_word(value);
   endtask

   task write_modulus(logic [30:0] m);
      req_valid <= 1'b0;
      wait (sb.pending.size() == 0);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.modulus = m;
   endtask

   function logic [30:0] random_word(logic [30:0] m);
      case ($urandom_range(0, 3))
         0:       return (m > 0) ? 31'($urandom % m) : 31'($urandom);
         1:       return (m > 0) ? 31'(m * $urandom_range(0, 3)) : '0;
         default: return 31'($urandom);
      endcase
   endfunction

   // receiver: random stall per word, one long hold-off, a calm stretch
   initial begin
      int n;
      wait (!reset);
      forever begin
         if (results_seen == 40) n = 8000;
         else if (results_seen >= 100 && results_seen < 140) n = 0;
         else n = $urandom_range(0, 15);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [30:0] moduli[10];
      logic [30:0] m;
      moduli = '{31'd2, MAX_WORD, 31'd3, 31'd15, 31'd0, 31'd1, 31'd65537,
                 31'($urandom) | 31'd1, MAX_WORD, 31'd1000003};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 10; p++) begin
         m = moduli[p];
         quiet_sender = (p == 3);
         if (p > 0) write_modulus(m);
         if (p == 1 || p == 3 || p == 6) begin
            send_word('0);
            send_word(31'd1);
            send_word(31'd2);
            send_word(m - 31'd1);
            send_word(m);
            send_word(m + 31'd1);
            send_word(31'(m * 2));
            send_word(MAX_WORD);
            if (p == 3) begin
               send_word(31'd5);
               send_word(31'd6);
            end
         end
         for (int i = 0; i < 24; i++) send_word(random_word(m));
      end
      req_valid <= 1'b0;
      wait (sb.pending.size() == 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("FAIL");
      $finish;
   end
endmodule
